[src/mams_pkg.sv]
// Shared types, constants and the microcode table for the momentum sum unit.
// Used by every module in this block; depends on nothing else.
`default_nettype none

package mams_pkg;

  // Field widths and block constants.
  localparam int MASS_W      = 16;
  localparam int CRD_W       = 20;   // width of a coordinate field on the port
  localparam int COORD_WIDTH = 20;   // low bits of a coordinate field that carry the value
  localparam int MAX_BODIES  = 256;
  localparam int CNT_W       = $clog2(MAX_BODIES + 1);
  localparam int MOM_W       = 44;
  localparam int ANG_W       = 64;
  localparam int MAG_W       = 64;
  localparam int HALF_W      = MAG_W / 2;
  localparam int OP_W        = HALF_W + 1;    // signed multiplier operand
  localparam int PROD_W      = 2 * OP_W;
  localparam int ACC_W       = 2 * MAG_W;     // holds a full sum of squares
  localparam int CRS_W       = 2 * CRD_W + 1; // one cross product component
  localparam int CL_W        = 24;            // low, unsigned part of a cross component
  localparam int REM_W       = MAG_W + 2;
  localparam int SQ_ITER     = MAG_W;
  localparam int SQ_CNT_W    = $clog2(SQ_ITER);
  localparam int PC_W        = 5;

  // Multiplier operand sources.
  typedef logic [3:0] src_t;
  localparam src_t SRC_ZERO = 4'd0;
  localparam src_t SRC_MASS = 4'd1;
  localparam src_t SRC_RX   = 4'd2;
  localparam src_t SRC_RY   = 4'd3;
  localparam src_t SRC_RZ   = 4'd4;
  localparam src_t SRC_VX   = 4'd5;
  localparam src_t SRC_VY   = 4'd6;
  localparam src_t SRC_VZ   = 4'd7;
  localparam src_t SRC_CL   = 4'd8;
  localparam src_t SRC_CH   = 4'd9;
  localparam src_t SRC_SQL  = 4'd10;
  localparam src_t SRC_SQH  = 4'd11;

  // Accumulator operations.
  typedef logic [1:0] acc_op_t;
  localparam acc_op_t ACC_NOP = 2'd0;
  localparam acc_op_t ACC_LD  = 2'd1;
  localparam acc_op_t ACC_ADD = 2'd2;
  localparam acc_op_t ACC_SUB = 2'd3;

  // Left shift applied to the product before it reaches the accumulator.
  typedef logic [1:0] sh_t;
  localparam sh_t SH_0  = 2'd0;
  localparam sh_t SH_24 = 2'd1;
  localparam sh_t SH_33 = 2'd2;
  localparam sh_t SH_64 = 2'd3;

  // Saturating commit of the accumulator into one of the running sums.
  typedef logic [2:0] cmt_t;
  localparam cmt_t CMT_NONE = 3'd0;
  localparam cmt_t CMT_MX   = 3'd1;
  localparam cmt_t CMT_MY   = 3'd2;
  localparam cmt_t CMT_MZ   = 3'd3;
  localparam cmt_t CMT_AX   = 3'd4;
  localparam cmt_t CMT_AY   = 3'd5;
  localparam cmt_t CMT_AZ   = 3'd6;

  typedef logic [1:0] axis_t;
  localparam axis_t AXIS_X = 2'd0;
  localparam axis_t AXIS_Y = 2'd1;
  localparam axis_t AXIS_Z = 2'd2;

  // Sequencer operations.
  typedef logic [2:0] seq_t;
  localparam seq_t SEQ_NEXT     = 3'd0;
  localparam seq_t SEQ_BODY_END = 3'd1;
  localparam seq_t SEQ_SQRT_GO  = 3'd2;
  localparam seq_t SEQ_FINISH   = 3'd3;

  typedef struct packed {
    src_t    src_a;
    src_t    src_b;
    acc_op_t acc_op;
    sh_t     sh;
    logic    crs_ld;
    cmt_t    cmt;
    axis_t   axis;
    seq_t    seq;
  } ctl_t;

  typedef struct packed {
    logic [MASS_W-1:0]       mass;
    logic signed [CRD_W-1:0] rx;
    logic signed [CRD_W-1:0] ry;
    logic signed [CRD_W-1:0] rz;
    logic signed [CRD_W-1:0] vx;
    logic signed [CRD_W-1:0] vy;
    logic signed [CRD_W-1:0] vz;
  } body_t;

  // Status that the sequencer consumes.
  typedef struct packed {
    logic start;
    logic close;
    logic sq_busy;
    logic out_blocked;
  } seq_in_t;

  // Events that the sequencer produces.
  typedef struct packed {
    logic run;
    logic sq_start;
    logic emit;
  } seq_ev_t;

  // Sign-extends the low COORD_WIDTH bits of a coordinate field.
  function automatic logic signed [CRD_W-1:0] crd_ext(input logic [CRD_W-1:0] raw);
    logic signed [CRD_W-1:0] t;
    t = $signed(raw << (CRD_W - COORD_WIDTH));
    return t >>> (CRD_W - COORD_WIDTH);
  endfunction

  function automatic ctl_t mk(input src_t a, input src_t b, input acc_op_t op,
                              input sh_t sh, input logic crs, input cmt_t cmt,
                              input axis_t ax, input seq_t sq);
    ctl_t c;
    c.src_a  = a;
    c.src_b  = b;
    c.acc_op = op;
    c.sh     = sh;
    c.crs_ld = crs;
    c.cmt    = cmt;
    c.axis   = ax;
    c.seq    = sq;
    return c;
  endfunction

  localparam ctl_t CTL_IDLE = '0;

  // Microcode. The multiplier result is registered, so an accumulator
  // operation always consumes the product issued one step earlier.
  function automatic ctl_t ucode_rom(input logic [PC_W-1:0] pc);
    ctl_t c;
    case (pc)
      // m * v for the three axes
      PC_W'(0):  c = mk(SRC_MASS, SRC_VX, ACC_NOP, SH_0, 1'b0, CMT_NONE, AXIS_X, SEQ_NEXT);
      PC_W'(1):  c = mk(SRC_MASS, SRC_VY, ACC_LD,  SH_0, 1'b0, CMT_NONE, AXIS_X, SEQ_NEXT);
      PC_W'(2):  c = mk(SRC_MASS, SRC_VZ, ACC_LD,  SH_0, 1'b0, CMT_MX,   AXIS_X, SEQ_NEXT);
      PC_W'(3):  c = mk(SRC_RY,   SRC_VZ, ACC_LD,  SH_0, 1'b0, CMT_MY,   AXIS_X, SEQ_NEXT);
      // x component of r x v, then scaled by m
      PC_W'(4):  c = mk(SRC_RZ,   SRC_VY, ACC_LD,  SH_0, 1'b0, CMT_MZ,   AXIS_X, SEQ_NEXT);
      PC_W'(5):  c = mk(SRC_ZERO, SRC_ZERO, ACC_SUB, SH_0, 1'b1, CMT_NONE, AXIS_X, SEQ_NEXT);
      PC_W'(6):  c = mk(SRC_MASS, SRC_CL, ACC_NOP, SH_0, 1'b0, CMT_NONE, AXIS_X, SEQ_NEXT);
      PC_W'(7):  c = mk(SRC_MASS, SRC_CH, ACC_LD,  SH_0, 1'b0, CMT_NONE, AXIS_X, SEQ_NEXT);
      PC_W'(8):  c = mk(SRC_RZ,   SRC_VX, ACC_ADD, SH_24, 1'b0, CMT_NONE, AXIS_X, SEQ_NEXT);
      // y component
      PC_W'(9):  c = mk(SRC_RX,   SRC_VZ, ACC_LD,  SH_0, 1'b0, CMT_AX,   AXIS_X, SEQ_NEXT);
      PC_W'(10): c = mk(SRC_ZERO, SRC_ZERO, ACC_SUB, SH_0, 1'b1, CMT_NONE, AXIS_X, SEQ_NEXT);
      PC_W'(11): c = mk(SRC_MASS, SRC_CL, ACC_NOP, SH_0, 1'b0, CMT_NONE, AXIS_X, SEQ_NEXT);
      PC_W'(12): c = mk(SRC_MASS, SRC_CH, ACC_LD,  SH_0, 1'b0, CMT_NONE, AXIS_X, SEQ_NEXT);
      PC_W'(13): c = mk(SRC_RX,   SRC_VY, ACC_ADD, SH_24, 1'b0, CMT_NONE, AXIS_X, SEQ_NEXT);
      // z component
      PC_W'(14): c = mk(SRC_RY,   SRC_VX, ACC_LD,  SH_0, 1'b0, CMT_AY,   AXIS_X, SEQ_NEXT);
      PC_W'(15): c = mk(SRC_ZERO, SRC_ZERO, ACC_SUB, SH_0, 1'b1, CMT_NONE, AXIS_X, SEQ_NEXT);
      PC_W'(16): c = mk(SRC_MASS, SRC_CL, ACC_NOP, SH_0, 1'b0, CMT_NONE, AXIS_X, SEQ_NEXT);
      PC_W'(17): c = mk(SRC_MASS, SRC_CH, ACC_LD,  SH_0, 1'b0, CMT_NONE, AXIS_X, SEQ_NEXT);
      PC_W'(18): c = mk(SRC_ZERO, SRC_ZERO, ACC_ADD, SH_24, 1'b0, CMT_NONE, AXIS_X, SEQ_NEXT);
      PC_W'(19): c = mk(SRC_ZERO, SRC_ZERO, ACC_NOP, SH_0, 1'b0, CMT_AZ, AXIS_X, SEQ_BODY_END);
      // Sum of squares of the angular sums, 32-bit halves at a time
      PC_W'(20): c = mk(SRC_SQL,  SRC_SQL, ACC_NOP, SH_0,  1'b0, CMT_NONE, AXIS_X, SEQ_NEXT);
      PC_W'(21): c = mk(SRC_SQL,  SRC_SQH, ACC_LD,  SH_0,  1'b0, CMT_NONE, AXIS_X, SEQ_NEXT);
      PC_W'(22): c = mk(SRC_SQH,  SRC_SQH, ACC_ADD, SH_33, 1'b0, CMT_NONE, AXIS_X, SEQ_NEXT);
      PC_W'(23): c = mk(SRC_SQL,  SRC_SQL, ACC_ADD, SH_64, 1'b0, CMT_NONE, AXIS_Y, SEQ_NEXT);
      PC_W'(24): c = mk(SRC_SQL,  SRC_SQH, ACC_ADD, SH_0,  1'b0, CMT_NONE, AXIS_Y, SEQ_NEXT);
      PC_W'(25): c = mk(SRC_SQH,  SRC_SQH, ACC_ADD, SH_33, 1'b0, CMT_NONE, AXIS_Y, SEQ_NEXT);
      PC_W'(26): c = mk(SRC_SQL,  SRC_SQL, ACC_ADD, SH_64, 1'b0, CMT_NONE, AXIS_Z, SEQ_NEXT);
      PC_W'(27): c = mk(SRC_SQL,  SRC_SQH, ACC_ADD, SH_0,  1'b0, CMT_NONE, AXIS_Z, SEQ_NEXT);
      PC_W'(28): c = mk(SRC_SQH,  SRC_SQH, ACC_ADD, SH_33, 1'b0, CMT_NONE, AXIS_Z, SEQ_NEXT);
      PC_W'(29): c = mk(SRC_ZERO, SRC_ZERO, ACC_ADD, SH_64, 1'b0, CMT_NONE, AXIS_X, SEQ_NEXT);
      PC_W'(30): c = mk(SRC_ZERO, SRC_ZERO, ACC_NOP, SH_0, 1'b0, CMT_NONE, AXIS_X, SEQ_SQRT_GO);
      PC_W'(31): c = mk(SRC_ZERO, SRC_ZERO, ACC_NOP, SH_0, 1'b0, CMT_NONE, AXIS_X, SEQ_FINISH);
      default:   c = CTL_IDLE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[src/momentum_angular_momentum_sum_unit.sv]
// Total linear and angular momentum of a set of bodies, microcoded.
// A body that does not close its set occupies the unit for its whole program, so a new
// request is taken only after that program ends; the 33x33 multiplier is shared by all steps.
// A closing body adds sum-of-squares work and a square root: its result is in the output
// register once the root is ready and the output register is free.
// rst_n (synchronous, active low) clears the sums, the flag, the body count and all handshakes.
`default_nettype none

module momentum_angular_momentum_sum_unit
  import mams_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,

  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [MASS_W-1:0]       in_body_mass,
  input  wire logic signed [CRD_W-1:0] in_position_x,
  input  wire logic signed [CRD_W-1:0] in_position_y,
  input  wire logic signed [CRD_W-1:0] in_position_z,
  input  wire logic signed [CRD_W-1:0] in_velocity_x,
  input  wire logic signed [CRD_W-1:0] in_velocity_y,
  input  wire logic signed [CRD_W-1:0] in_velocity_z,
  input  wire logic                    in_last_body,

  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [MOM_W-1:0]      out_momentum_x,
  output logic signed [MOM_W-1:0]      out_momentum_y,
  output logic signed [MOM_W-1:0]      out_momentum_z,
  output logic signed [ANG_W-1:0]      out_angular_x,
  output logic signed [ANG_W-1:0]      out_angular_y,
  output logic signed [ANG_W-1:0]      out_angular_z,
  output logic [MAG_W-1:0]             out_angular_magnitude,
  output logic                         out_overflow_flag
);

  // The request port is stalled for as long as the sequencer runs a program.
  // The output register is separate, so a finished result may wait on the
  // result port while the next body is already being worked on.

  ctl_t                  ctl;
  seq_in_t               stat;
  seq_ev_t               ev;
  logic                  in_take;

  body_t                 body_r;
  logic                  close_r;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  close_now;

  logic [2:0][MOM_W-1:0] mom_sum;
  logic [2:0][ANG_W-1:0] ang_sum;
  logic                  sat_seen;
  logic [ACC_W-1:0]      acc;
  logic                  sq_busy;
  logic [MAG_W-1:0]      sq_root;

  logic                  out_valid_r, out_valid_nxt;
  logic [2:0][MOM_W-1:0] out_mom_r;
  logic [2:0][ANG_W-1:0] out_ang_r;
  logic [MAG_W-1:0]      out_mag_r;
  logic                  out_ovf_r;

  assign in_stall = ev.run;
  assign in_take  = in_valid && !in_stall;

  // A set closes on the marked body or on the body that fills it; the count
  // is restarted right away since later bodies wait for this one anyway.
  assign close_now = in_last_body || (count_r == CNT_W'(MAX_BODIES - 1));
  assign count_nxt = close_now ? '0 : count_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      close_r <= 1'b0;
    end else if (in_take) begin
      count_r <= count_nxt;
      close_r <= close_now;
    end
  end

  // Body latch; coordinates are narrowed to COORD_WIDTH bits here.
  always_ff @(posedge clk) begin
    if (in_take) begin
      body_r.mass <= in_body_mass;
      body_r.rx   <= crd_ext(in_position_x);
      body_r.ry   <= crd_ext(in_position_y);
      body_r.rz   <= crd_ext(in_position_z);
      body_r.vx   <= crd_ext(in_velocity_x);
      body_r.vy   <= crd_ext(in_velocity_y);
      body_r.vz   <= crd_ext(in_velocity_z);
    end
  end

  // The final step of a closing body holds until the root is ready and the
  // output register is free (or is being emptied in this very cycle).
  assign stat.start       = in_take;
  assign stat.close       = close_r;
  assign stat.sq_busy     = sq_busy;
  assign stat.out_blocked = out_valid_r && out_stall;

  mams_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl),
    .ev    (ev)
  );

  mams_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .body     (body_r),
    .clear    (ev.emit),
    .mom_sum  (mom_sum),
    .ang_sum  (ang_sum),
    .sat_seen (sat_seen),
    .acc      (acc)
  );

  // The accumulator holds the full sum of squares when the root is started.
  mams_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ev.sq_start),
    .radicand (acc),
    .busy     (sq_busy),
    .root     (sq_root)
  );

  // Result register. On emit the datapath clears its sums in the same edge
  // that copies them here.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (ev.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (ev.emit) begin
      out_mom_r <= mom_sum;
      out_ang_r <= ang_sum;
      out_mag_r <= sq_root;
      out_ovf_r <= sat_seen;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_momentum_x        = out_mom_r[AXIS_X];
  assign out_momentum_y        = out_mom_r[AXIS_Y];
  assign out_momentum_z        = out_mom_r[AXIS_Z];
  assign out_angular_x         = out_ang_r[AXIS_X];
  assign out_angular_y         = out_ang_r[AXIS_Y];
  assign out_angular_z         = out_ang_r[AXIS_Z];
  assign out_angular_magnitude = out_mag_r;
  assign out_overflow_flag     = out_ovf_r;

endmodule

`default_nettype wire

[src/mams_isqrt.sv]
// Integer square root of a 128-bit radicand, one result bit per cycle.
// Depends on mams_pkg.
`default_nettype none

module mams_isqrt
  import mams_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [ACC_W-1:0] radicand,
  output logic                  busy,
  output logic [MAG_W-1:0]      root
);

  logic                busy_r, busy_nxt;
  logic [SQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [MAG_W-1:0]    root_r, root_nxt;
  logic [ACC_W-1:0]    rad_r, rad_nxt;
  logic [REM_W+1:0]    shifted, trial, diff;
  logic                ge;

  always_comb begin
    shifted  = {rem_r, rad_r[ACC_W-1 -: 2]};
    trial    = {2'b00, root_r, 2'b01};
    diff     = shifted - trial;
    ge       = (shifted >= trial);
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    rad_nxt  = rad_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = SQ_CNT_W'(SQ_ITER - 1);
      rem_nxt  = '0;
      root_nxt = '0;
      rad_nxt  = radicand;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
      root_nxt = {root_r[MAG_W-2:0], ge};
      rad_nxt  = rad_r << 2;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    rad_r  <= rad_nxt;
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

`default_nettype wire

[src/mams_seq.sv]
// Microcode sequencer: step counter, control word lookup and conditional ends and holds.
// Depends on mams_pkg for the control word and the program table.
`default_nettype none

module mams_seq
  import mams_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire seq_in_t stat,
  output ctl_t         ctl,
  output seq_ev_t      ev
);

  logic            run_r, run_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;

  assign ctl = run_r ? ucode_rom(pc_r) : CTL_IDLE;

  always_comb begin
    run_nxt     = run_r;
    pc_nxt      = pc_r;
    ev.run      = run_r;
    ev.sq_start = 1'b0;
    ev.emit     = 1'b0;
    if (!run_r) begin
      if (stat.start) begin
        run_nxt = 1'b1;
        pc_nxt  = '0;
      end
    end else begin
      case (ctl.seq)
        SEQ_NEXT: begin
          pc_nxt = pc_r + 1'b1;
        end
        SEQ_BODY_END: begin
          // Only a body that closes the set goes on to the magnitude.
          if (stat.close) begin
            pc_nxt = pc_r + 1'b1;
          end else begin
            run_nxt = 1'b0;
          end
        end
        SEQ_SQRT_GO: begin
          ev.sq_start = 1'b1;
          pc_nxt      = pc_r + 1'b1;
        end
        SEQ_FINISH: begin
          if (!stat.sq_busy && !stat.out_blocked) begin
            ev.emit = 1'b1;
            run_nxt = 1'b0;
          end
        end
        default: begin
          run_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      pc_r  <= '0;
    end else begin
      run_r <= run_nxt;
      pc_r  <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

[src/mams_dp.sv]
// Datapath: shared multiplier, wide accumulator and the saturating running sums.
// Depends on mams_pkg; driven by the control word of mams_seq.
`default_nettype none

module mams_dp
  import mams_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ctl_t               ctl,
  input  wire body_t              body,
  input  wire logic               clear,
  output logic [2:0][MOM_W-1:0]   mom_sum,
  output logic [2:0][ANG_W-1:0]   ang_sum,
  output logic                    sat_seen,
  output logic [ACC_W-1:0]        acc
);

  localparam logic [MOM_W-1:0] MOM_MAX = {1'b0, {(MOM_W-1){1'b1}}};
  localparam logic [MOM_W-1:0] MOM_MIN = {1'b1, {(MOM_W-1){1'b0}}};
  localparam logic [ANG_W-1:0] ANG_MAX = {1'b0, {(ANG_W-1){1'b1}}};
  localparam logic [ANG_W-1:0] ANG_MIN = {1'b1, {(ANG_W-1){1'b0}}};

  logic signed [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]         acc_r, acc_nxt;
  logic [CRS_W-1:0]         crs_r, crs_nxt;
  logic [2:0][MOM_W-1:0]    mom_r, mom_nxt;
  logic [2:0][ANG_W-1:0]    ang_r, ang_nxt;
  logic                     sat_r, sat_nxt;

  logic signed [OP_W-1:0]   op_a, op_b;
  logic [ANG_W-1:0]         sq_sel, sq_mag;
  logic [ACC_W-1:0]         prod_ext, prod_sh;
  logic                     mom_we, ang_we;
  axis_t                    mi, ai;
  logic signed [MOM_W+1:0]  ms;
  logic signed [ANG_W:0]    as;

  function automatic logic signed [OP_W-1:0] pick(input src_t s, input body_t b,
                                                  input logic [CRS_W-1:0] c,
                                                  input logic [ANG_W-1:0] mag);
    logic signed [OP_W-1:0] v;
    case (s)
      SRC_MASS: v = OP_W'(b.mass);
      SRC_RX:   v = OP_W'(b.rx);
      SRC_RY:   v = OP_W'(b.ry);
      SRC_RZ:   v = OP_W'(b.rz);
      SRC_VX:   v = OP_W'(b.vx);
      SRC_VY:   v = OP_W'(b.vy);
      SRC_VZ:   v = OP_W'(b.vz);
      SRC_CL:   v = OP_W'(c[CL_W-1:0]);
      SRC_CH:   v = OP_W'($signed(c[CRS_W-1:CL_W]));
      SRC_SQL:  v = OP_W'(mag[HALF_W-1:0]);
      SRC_SQH:  v = OP_W'(mag[MAG_W-1:HALF_W]);
      default:  v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    sq_sel = ang_r[ctl.axis];
    sq_mag = sq_sel[ANG_W-1] ? (~sq_sel + 1'b1) : sq_sel;
    op_a   = pick(ctl.src_a, body, crs_r, sq_mag);
    op_b   = pick(ctl.src_b, body, crs_r, sq_mag);
  end

  // Product alignment and accumulator update.
  always_comb begin
    prod_ext = ACC_W'(prod_r);
    case (ctl.sh)
      SH_0:    prod_sh = prod_ext;
      SH_24:   prod_sh = prod_ext << CL_W;
      SH_33:   prod_sh = prod_ext << (HALF_W + 1);
      SH_64:   prod_sh = prod_ext << MAG_W;
      default: prod_sh = '0;
    endcase
    case (ctl.acc_op)
      ACC_LD:  acc_nxt = prod_sh;
      ACC_ADD: acc_nxt = acc_r + prod_sh;
      ACC_SUB: acc_nxt = acc_r - prod_sh;
      default: acc_nxt = acc_r;
    endcase
    crs_nxt = ctl.crs_ld ? acc_nxt[CRS_W-1:0] : crs_r;
  end

  // Saturating commits into the running sums.
  always_comb begin
    mom_we = 1'b0;
    ang_we = 1'b0;
    mi     = AXIS_X;
    ai     = AXIS_X;
    case (ctl.cmt)
      CMT_MX: begin mom_we = 1'b1; mi = AXIS_X; end
      CMT_MY: begin mom_we = 1'b1; mi = AXIS_Y; end
      CMT_MZ: begin mom_we = 1'b1; mi = AXIS_Z; end
      CMT_AX: begin ang_we = 1'b1; ai = AXIS_X; end
      CMT_AY: begin ang_we = 1'b1; ai = AXIS_Y; end
      CMT_AZ: begin ang_we = 1'b1; ai = AXIS_Z; end
      default: begin end
    endcase

    ms = (MOM_W+2)'($signed(mom_r[mi])) + (MOM_W+2)'($signed(acc_r[MOM_W:0]));
    as = (ANG_W+1)'($signed(ang_r[ai])) + (ANG_W+1)'($signed(acc_r[ANG_W-1:0]));

    mom_nxt = mom_r;
    ang_nxt = ang_r;
    sat_nxt = sat_r;
    if (mom_we) begin
      if (!ms[MOM_W+1] && (ms[MOM_W+1:MOM_W-1] != 3'b000)) begin
        mom_nxt[mi] = MOM_MAX;
        sat_nxt     = 1'b1;
      end else if (ms[MOM_W+1] && (ms[MOM_W+1:MOM_W-1] != 3'b111)) begin
        mom_nxt[mi] = MOM_MIN;
        sat_nxt     = 1'b1;
      end else begin
        mom_nxt[mi] = ms[MOM_W-1:0];
      end
    end
    if (ang_we) begin
      if (as[ANG_W] != as[ANG_W-1]) begin
        ang_nxt[ai] = as[ANG_W] ? ANG_MIN : ANG_MAX;
        sat_nxt     = 1'b1;
      end else begin
        ang_nxt[ai] = as[ANG_W-1:0];
      end
    end
    if (clear) begin
      mom_nxt = '0;
      ang_nxt = '0;
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mom_r <= '0;
      ang_r <= '0;
      sat_r <= 1'b0;
    end else begin
      mom_r <= mom_nxt;
      ang_r <= ang_nxt;
      sat_r <= sat_nxt;
    end
    prod_r <= op_a * op_b;
    acc_r  <= acc_nxt;
    crs_r  <= crs_nxt;
  end

  assign mom_sum  = mom_r;
  assign ang_sum  = ang_r;
  assign sat_seen = sat_r;
  assign acc      = acc_r;

endmodule

`default_nettype wire
